[rtl/ftb_pkg.sv]
package ftb_pkg;

   // Input operation codes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAKE_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAKE_PULSES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_PERIOD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ONE_PULSES  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_PERIOD = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_PULSES = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERM_PERIOD = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_TERM_PULSES = 3'd7;

   localparam int PERIOD_W = 8;
   localparam int PULSES_W = 6;
   localparam int BYTE_W   = 8;
   localparam int BIT_W    = 3;

   // Reset values of the configuration registers.
   localparam logic [PERIOD_W-1:0] WAKE_PERIOD_RST = 8'd46;
   localparam logic [PULSES_W-1:0] WAKE_PULSES_RST = 6'd21;
   localparam logic [PERIOD_W-1:0] ONE_PERIOD_RST  = 8'd76;
   localparam logic [PULSES_W-1:0] ONE_PULSES_RST  = 6'd11;
   localparam logic [PERIOD_W-1:0] ZERO_PERIOD_RST = 8'd58;
   localparam logic [PULSES_W-1:0] ZERO_PULSES_RST = 6'd14;
   localparam logic [PERIOD_W-1:0] TERM_PERIOD_RST = 8'd110;
   localparam logic [PULSES_W-1:0] TERM_PULSES_RST = 6'd5;

   // Depth of the command and result queues.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic              is_offer;
      logic              is_start;
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } cmd_type;

   typedef struct packed {
      logic pin_level;
      logic byte_taken;
      logic need_byte;
      logic frame_active;
      logic frame_done;
   } rsp_type;

endpackage

[rtl/fsk_tone_burst_transmitter_core.sv]
// Channel   Ports                                       Beat when
// -------   -----------------------------------------   ----------------------
// request   push, full, req_op/data_byte/last_byte      push high, full low
// result    empty, pop, rsp_pin_level ... frame_done    pop high, empty low
// csr       csr_valid, csr_ready, csr_index, csr_data   csr_valid and csr_ready
//
// Each request beat is one timer tick and yields exactly one result beat.
// A tick is handled by the tone engine; with both sides moving, one beat
// passes per cycle, and a result reaches the result ports once its request
// beat has been registered in the request queue and then in the result queue.
// Two-entry queues on each side of the engine let either side stall alone.
// Reset is synchronous; csr_ready is always high.
module fsk_tone_burst_transmitter_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [1:0]                      req_op,
   input  logic [ftb_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            empty,
   input  logic                            pop,
   output logic                            rsp_pin_level,
   output logic                            rsp_byte_taken,
   output logic                            rsp_need_byte,
   output logic                            rsp_frame_active,
   output logic                            rsp_frame_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ftb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ftb_pkg::BYTE_W-1:0]      csr_data
);
   import ftb_pkg::*;

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_take;
   logic    rsp_push;
   rsp_type rsp_in;
   logic    rsp_full;
   rsp_type rsp_out;

   ftb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   ftb_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_push  (rsp_push),
      .rsp       (rsp_in),
      .rsp_full  (rsp_full)
   );

   ftb_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .rsp_push     (rsp_push),
      .rsp_in_data  (rsp_in),
      .rsp_full     (rsp_full),
      .pop          (pop),
      .empty        (empty),
      .rsp_out_data (rsp_out)
   );

   assign rsp_pin_level    = rsp_out.pin_level;
   assign rsp_byte_taken   = rsp_out.byte_taken;
   assign rsp_need_byte    = rsp_out.need_byte;
   assign rsp_frame_active = rsp_out.frame_active;
   assign rsp_frame_done   = rsp_out.frame_done;

endmodule

[rtl/ftb_front.sv]
module ftb_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic [1:0]                req_op,
   input  logic [ftb_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                      req_last_byte,
   output logic                      cmd_valid,
   output ftb_pkg::cmd_type          cmd,
   input  logic                      cmd_take
);
   import ftb_pkg::*;

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   cmd_type            decoded;
   logic               wr_en;
   logic               rd_en;

   // Op code 3 decodes to neither flag and so acts as a plain tick.
   always_comb begin
      decoded.is_offer  = (req_op == OP_BYTE);
      decoded.is_start  = (req_op == OP_START);
      decoded.data_byte = req_data_byte;
      decoded.last_byte = req_last_byte;
   end

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign wr_en     = push && !full;
   assign rd_en     = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[rtl/ftb_engine.sv]
module ftb_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ftb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ftb_pkg::BYTE_W-1:0]    csr_data,
   input  logic                          cmd_valid,
   input  ftb_pkg::cmd_type              cmd,
   output logic                          cmd_take,
   output logic                          rsp_push,
   output ftb_pkg::rsp_type              rsp,
   input  logic                          rsp_full
);
   import ftb_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAKE,
      PH_DATA,
      PH_TERM
   } phase_type;

   logic [PERIOD_W-1:0] wake_period_ff, one_period_ff, zero_period_ff, term_period_ff;
   logic [PULSES_W-1:0] wake_pulses_ff, one_pulses_ff, zero_pulses_ff, term_pulses_ff;

   phase_type           phase_ff, phase_in;
   logic [PERIOD_W-1:0] tick_ff, tick_in;
   logic [PULSES_W-1:0] pulse_ff, pulse_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic                shift_last_ff, shift_last_in;
   logic [BYTE_W-1:0]   hold_byte_ff, hold_byte_in;
   logic                hold_valid_ff, hold_valid_in;
   logic                hold_last_ff, hold_last_in;
   logic                closed_ff, closed_in;

   logic [PERIOD_W-1:0] per;
   logic [PULSES_W-1:0] pul;
   logic [PULSES_W-1:0] pulse_next;
   logic                go_next;
   logic                fire;
   rsp_type             result;

   assign csr_ready = 1'b1;
   assign fire      = cmd_valid && !rsp_full;
   assign cmd_take  = fire;
   assign rsp_push  = fire;
   assign rsp       = result;

   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      pulse_in      = pulse_ff;
      bit_in        = bit_ff;
      shift_in      = shift_ff;
      shift_last_in = shift_last_ff;
      hold_byte_in  = hold_byte_ff;
      hold_valid_in = hold_valid_ff;
      hold_last_in  = hold_last_ff;
      closed_in     = closed_ff;
      per           = zero_period_ff;
      pul           = zero_pulses_ff;
      pulse_next    = pulse_ff + 1'b1;
      go_next       = 1'b0;
      result        = '0;

      // The offered input is taken before the tone logic looks at the state.
      if (phase_ff == PH_IDLE) begin
         if (cmd.is_offer || cmd.is_start) begin
            phase_in = PH_WAKE;
            tick_in  = '0;
            pulse_in = '0;
            bit_in   = '0;
            if (cmd.is_offer) begin
               hold_byte_in  = cmd.data_byte;
               hold_valid_in = 1'b1;
               hold_last_in  = cmd.last_byte;
               closed_in     = cmd.last_byte;
            end else begin
               hold_valid_in = 1'b0;
               hold_last_in  = 1'b0;
               closed_in     = 1'b1;
            end
            result.byte_taken = 1'b1;
         end
      end else if (cmd.is_offer && !hold_valid_ff && !closed_ff) begin
         hold_byte_in      = cmd.data_byte;
         hold_valid_in     = 1'b1;
         hold_last_in      = cmd.last_byte;
         closed_in         = cmd.last_byte;
         result.byte_taken = 1'b1;
      end

      pulse_next = pulse_in + 1'b1;

      if (phase_in != PH_IDLE) begin
         result.frame_active = 1'b1;
         unique case (phase_in)
            PH_WAKE: begin
               per = wake_period_ff;
               pul = wake_pulses_ff;
            end
            PH_TERM: begin
               per = term_period_ff;
               pul = term_pulses_ff;
            end
            default: begin
               per = shift_ff[BYTE_W-1] ? one_period_ff : zero_period_ff;
               pul = shift_ff[BYTE_W-1] ? one_pulses_ff : zero_pulses_ff;
            end
         endcase
         result.pin_level = (tick_in < (per >> 1));
         if (tick_in >= per) begin
            tick_in = '0;
            if ((pul == '0) || (pulse_next >= pul)) begin
               pulse_in = '0;
               unique case (phase_in)
                  PH_WAKE: begin
                     go_next = 1'b1;
                  end
                  PH_DATA: begin
                     shift_in = {shift_ff[BYTE_W-2:0], 1'b0};
                     if (bit_in == BIT_W'(BYTE_W - 1)) begin
                        bit_in = '0;
                        if (shift_last_ff) begin
                           closed_in = 1'b1;
                           phase_in  = PH_TERM;
                        end else begin
                           go_next = 1'b1;
                        end
                     end else begin
                        bit_in = bit_in + 1'b1;
                     end
                  end
                  default: begin
                     phase_in          = PH_IDLE;
                     result.frame_done = 1'b1;
                     bit_in            = '0;
                     shift_in          = '0;
                     shift_last_in     = 1'b0;
                     hold_valid_in     = 1'b0;
                     hold_last_in      = 1'b0;
                     closed_in         = 1'b0;
                  end
               endcase
            end else begin
               pulse_in = pulse_next;
            end
         end else begin
            tick_in = tick_in + 1'b1;
         end
      end

      // After the wake burst or a non-final byte, the held byte moves to the
      // shifter; with none held the frame goes straight to its termination burst.
      if (go_next) begin
         tick_in  = '0;
         pulse_in = '0;
         if (hold_valid_in) begin
            shift_in      = hold_byte_in;
            shift_last_in = hold_last_in;
            hold_valid_in = 1'b0;
            bit_in        = '0;
            phase_in      = PH_DATA;
         end else begin
            closed_in = 1'b1;
            phase_in  = PH_TERM;
         end
      end

      result.need_byte = (phase_in != PH_IDLE) && !hold_valid_in && !closed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wake_period_ff <= WAKE_PERIOD_RST;
         wake_pulses_ff <= WAKE_PULSES_RST;
         one_period_ff  <= ONE_PERIOD_RST;
         one_pulses_ff  <= ONE_PULSES_RST;
         zero_period_ff <= ZERO_PERIOD_RST;
         zero_pulses_ff <= ZERO_PULSES_RST;
         term_period_ff <= TERM_PERIOD_RST;
         term_pulses_ff <= TERM_PULSES_RST;
         phase_ff       <= PH_IDLE;
         tick_ff        <= '0;
         pulse_ff       <= '0;
         bit_ff         <= '0;
         shift_ff       <= '0;
         shift_last_ff  <= 1'b0;
         hold_valid_ff  <= 1'b0;
         hold_last_ff   <= 1'b0;
         closed_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_WAKE_PERIOD: wake_period_ff <= csr_data;
               CSR_WAKE_PULSES: wake_pulses_ff <= csr_data[PULSES_W-1:0];
               CSR_ONE_PERIOD:  one_period_ff  <= csr_data;
               CSR_ONE_PULSES:  one_pulses_ff  <= csr_data[PULSES_W-1:0];
               CSR_ZERO_PERIOD: zero_period_ff <= csr_data;
               CSR_ZERO_PULSES: zero_pulses_ff <= csr_data[PULSES_W-1:0];
               CSR_TERM_PERIOD: term_period_ff <= csr_data;
               default:         term_pulses_ff <= csr_data[PULSES_W-1:0];
            endcase
         end
         if (fire) begin
            phase_ff      <= phase_in;
            tick_ff       <= tick_in;
            pulse_ff      <= pulse_in;
            bit_ff        <= bit_in;
            shift_ff      <= shift_in;
            shift_last_ff <= shift_last_in;
            hold_valid_ff <= hold_valid_in;
            hold_last_ff  <= hold_last_in;
            closed_ff     <= closed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         hold_byte_ff <= hold_byte_in;
      end
   end

endmodule

[rtl/ftb_rsp_queue.sv]
module ftb_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             rsp_push,
   input  ftb_pkg::rsp_type rsp_in_data,
   output logic             rsp_full,
   input  logic             pop,
   output logic             empty,
   output ftb_pkg::rsp_type rsp_out_data
);
   import ftb_pkg::*;

   rsp_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               wr_en;
   logic               rd_en;

   assign rsp_full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty        = (count_ff == '0);
   assign rsp_out_data = entry_ff[rd_ptr_ff];
   assign wr_en        = rsp_push && !rsp_full;
   assign rd_en        = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= rsp_in_data;
      end
   end

endmodule
